// File: hdl/playout_delay_adapter_top_assert.svh
// assertion macros for the playout delay adapter top level
// used by playout_delay_adapter_top.sv, expects clk and rst_n in scope
`ifndef PLAYOUT_DELAY_ADAPTER_TOP_ASSERT_SVH
`define PLAYOUT_DELAY_ADAPTER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PDA_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PDA_ASSERT_NXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pda_pkg.sv
// shared types, constants and helpers of the playout delay adapter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pda_pkg;

  // field widths
  localparam int TS_W     = 32;
  localparam int SEQ_W    = 16;
  localparam int CONC_W   = 8;
  localparam int CFG_W    = 16;
  localparam int JIT_W    = 40;
  localparam int CFG_IDX_W = 2;

  // jitter estimator constants
  localparam int JIT_INIT_INT  = 80;
  localparam int JIT_FRAC_BITS = 8;
  localparam int JIT_AVG_SHIFT = 4;
  localparam int JIT_MULT      = 3;
  localparam int JIT_CLAMP     = 8000;
  localparam int GAP_SHIFT     = 3;   // gap span of eight units
  localparam int CONCEAL_LIMIT = 4;

  localparam logic [JIT_W-1:0] JIT_INIT = JIT_W'(JIT_INIT_INT) << JIT_FRAC_BITS;

  // jitter term: largest integer jitter that stays under the clamp once tripled
  localparam int TERM_LIMIT = JIT_CLAMP / JIT_MULT;
  localparam int JINT_W     = $clog2(TERM_LIMIT + 1);
  localparam int TERM_W     = $clog2(JIT_CLAMP + 1);

  // register reset values
  localparam logic [CFG_W-1:0] UNIT_LENGTH_RST = CFG_W'(160);
  localparam logic [CFG_W-1:0] CUSHION_RST     = '0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSHION       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_DIFFERS = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] unit_length;
    logic [CFG_W-1:0] cushion_samples;
    logic             clock_differs;
  } cfg_t;

  typedef struct packed {
    logic            ts_advance;   // timestamp later than the stored one
    logic            updated;      // offset recomputed
    logic [TS_W-1:0] offset_nxt;
  } ofs_res_t;

  // a is later than b in wrapping timestamp order
  function automatic logic ts_later(input logic [TS_W-1:0] a, input logic [TS_W-1:0] b);
    logic [TS_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TS_W-1];
  endfunction

endpackage

// File: hdl/pda_jitter.sv
// interarrival jitter update and clamped jitter term
// depends on pda_pkg
`timescale 1ns / 1ps

module pda_jitter (
  input  logic [pda_pkg::TS_W-1:0]   delay,
  input  logic [pda_pkg::TS_W-1:0]   last_delay,
  input  logic [pda_pkg::JIT_W-1:0]  jitter,
  input  logic                       fresh,
  output logic [pda_pkg::JIT_W-1:0]  jitter_nxt,
  output logic [pda_pkg::TERM_W-1:0] term
);
  import pda_pkg::*;

  localparam int DIFF_W  = TS_W + 1;
  localparam int SHL_W   = DIFF_W + JIT_FRAC_BITS;
  localparam int T_W     = SHL_W + 1;

  logic signed [DIFF_W-1:0] ddiff;
  logic        [DIFF_W-1:0] dabs;
  logic signed [T_W-1:0]    t;
  logic signed [T_W-1:0]    step;
  logic        [T_W-1:0]    sum;
  logic        [TS_W-1:0]   jint;
  logic        [TERM_W-1:0] term_prod;

  // absolute delay change, exact up to 2^32
  always_comb begin
    ddiff = $signed({delay[TS_W-1], delay}) - $signed({last_delay[TS_W-1], last_delay});
    dabs  = ddiff[DIFF_W-1] ? (~ddiff + 1'b1) : ddiff;
  end

  // running average by one sixteenth, rounding toward minus infinity
  always_comb begin
    t    = $signed({1'b0, dabs, {JIT_FRAC_BITS{1'b0}}}) - $signed({{(T_W-JIT_W){1'b0}}, jitter});
    step = t >>> JIT_AVG_SHIFT;
    sum  = {{(T_W-JIT_W){1'b0}}, jitter} + step;
    jitter_nxt = fresh ? JIT_INIT : sum[JIT_W-1:0];
  end

  // integer part times three, clamped
  always_comb begin
    jint      = jitter_nxt[JIT_W-1:JIT_FRAC_BITS];
    term_prod = {{(TERM_W-JINT_W){1'b0}}, jint[JINT_W-1:0]} * TERM_W'(JIT_MULT);
    term      = (jint > TS_W'(TERM_LIMIT)) ? TERM_W'(JIT_CLAMP) : term_prod;
  end

endmodule

// File: hdl/pda_offset.sv
// timestamp order, gap test and playout offset recompute
// depends on pda_pkg
`timescale 1ns / 1ps

module pda_offset (
  input  logic [pda_pkg::TS_W-1:0]   ts,
  input  logic [pda_pkg::SEQ_W-1:0]  seq,
  input  logic                       marker,
  input  logic [pda_pkg::CONC_W-1:0] concealed,
  input  logic                       fresh,
  input  logic [pda_pkg::TS_W-1:0]   delay,
  input  logic [pda_pkg::TERM_W-1:0] term,
  input  logic [pda_pkg::TS_W-1:0]   prev_ts,
  input  logic [pda_pkg::SEQ_W-1:0]  prev_seq,
  input  logic [pda_pkg::TS_W-1:0]   offset,
  input  pda_pkg::cfg_t              cfg,
  output pda_pkg::ofs_res_t          res
);
  import pda_pkg::*;

  logic [TS_W-1:0]  prev_eff;
  logic [SEQ_W:0]   sdiff;
  logic [TS_W-1:0]  sdiff_ext;
  logic [TS_W-1:0]  prod;
  logic [TS_W-1:0]  span;
  logic [TS_W-1:0]  limit;
  logic             readjust;
  logic [TS_W-1:0]  var_sum;

  // gap limit from the sequence step
  always_comb begin
    prev_eff  = fresh ? (ts - 1'b1) : prev_ts;
    sdiff     = {1'b0, seq} - {1'b0, prev_seq};
    sdiff_ext = {{(TS_W-SEQ_W-1){sdiff[SEQ_W]}}, sdiff};
    prod      = sdiff_ext * {{(TS_W-CFG_W){1'b0}}, cfg.unit_length};
    span      = prod << GAP_SHIFT;
    limit     = prev_eff + span + 1'b1;
  end

  // readjust at the first header, talkspurt start, long concealment or gap
  always_comb begin
    readjust = marker || fresh || (concealed > CONC_W'(CONCEAL_LIMIT)) || ts_later(ts, limit);
    var_sum  = TS_W'(term) + {{(TS_W-CFG_W){1'b0}}, cfg.cushion_samples}
             + (cfg.clock_differs ? {{(TS_W-CFG_W){1'b0}}, cfg.unit_length} : '0);
    res.ts_advance = ts_later(ts, prev_eff);
    res.updated    = res.ts_advance && readjust;
    res.offset_nxt = res.updated ? (delay + var_sum) : offset;
  end

endmodule

// File: hdl/playout_delay_adapter_top.sv
// Playout delay adapter: one packet header in, one playout point out.
// Input channel in_*: header fields with in_valid, in_stall back to the sender.
// Result channel out_*: playout_point and offset_updated with out_valid,
// out_stall driven by the receiver.
// Config channel cfg_*: index and 16-bit data, always ready, write only when idle.
// An accepted header passes the input register, then the result register,
// before out_valid. One header per cycle while the receiver does not stall;
// the estimator state is read and written in the same cycle between the two.
// A stalled receiver holds the result register; the input register still
// takes one more header, after which in_stall rises until the result moves.
// Reset (rst_n low, synchronous) empties both registers, restores
// unit_length 160, cushion 0, clock_differs 0, clears the estimator and
// marks the next header as the first one.
// Depends on pda_pkg, pda_jitter, pda_offset and the assertion header.
`timescale 1ns / 1ps

module playout_delay_adapter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pda_pkg::TS_W-1:0]      in_media_timestamp,
  input  logic [pda_pkg::SEQ_W-1:0]     in_sequence_number,
  input  logic                          in_marker_bit,
  input  logic [pda_pkg::TS_W-1:0]      in_arrival_time,
  input  logic [pda_pkg::CONC_W-1:0]    in_concealed_run,
  input  logic                          in_format_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pda_pkg::TS_W-1:0]      out_playout_point,
  output logic                          out_offset_updated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pda_pkg::CFG_W-1:0]     cfg_data
);
  import pda_pkg::*;

  `include "playout_delay_adapter_top_assert.svh"

  // configuration
  cfg_t cfg_r, cfg_nxt;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [TS_W-1:0]   s1_ts_r;
  logic [SEQ_W-1:0]  s1_seq_r;
  logic              s1_marker_r;
  logic [TS_W-1:0]   s1_arrival_r;
  logic [CONC_W-1:0] s1_conc_r;
  logic              s1_restart_r;

  // estimator state
  logic              fresh_r, fresh_nxt;
  logic [TS_W-1:0]   last_delay_r, last_delay_nxt;
  logic [JIT_W-1:0]  jitter_r, jitter_nxt;
  logic [TS_W-1:0]   prev_ts_r, prev_ts_nxt;
  logic [SEQ_W-1:0]  prev_seq_r, prev_seq_nxt;
  logic [TS_W-1:0]   offset_r, offset_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [TS_W-1:0]   out_point_r;
  logic              out_upd_r;

  logic              in_accept;
  logic              advance;
  logic              fresh_eff;
  logic [TS_W-1:0]   delay;
  logic [TERM_W-1:0] term;
  ofs_res_t          ofs;

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_UNIT_LENGTH:   cfg_nxt.unit_length     = cfg_data;
        CFG_CUSHION:       cfg_nxt.cushion_samples = cfg_data;
        CFG_CLOCK_DIFFERS: cfg_nxt.clock_differs   = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_length     <= UNIT_LENGTH_RST;
      cfg_r.cushion_samples <= CUSHION_RST;
      cfg_r.clock_differs   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  assign s1_valid_nxt = in_accept || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ts_r      <= in_media_timestamp;
      s1_seq_r     <= in_sequence_number;
      s1_marker_r  <= in_marker_bit;
      s1_arrival_r <= in_arrival_time;
      s1_conc_r    <= in_concealed_run;
      s1_restart_r <= in_format_restart;
    end
  end

  // per-request datapath
  assign fresh_eff = fresh_r || s1_restart_r;
  assign delay     = s1_arrival_r - s1_ts_r;

  pda_jitter u_jitter (
    .delay      (delay),
    .last_delay (last_delay_r),
    .jitter     (jitter_r),
    .fresh      (fresh_eff),
    .jitter_nxt (jitter_nxt),
    .term       (term)
  );

  pda_offset u_offset (
    .ts        (s1_ts_r),
    .seq       (s1_seq_r),
    .marker    (s1_marker_r),
    .concealed (s1_conc_r),
    .fresh     (fresh_eff),
    .delay     (delay),
    .term      (term),
    .prev_ts   (prev_ts_r),
    .prev_seq  (prev_seq_r),
    .offset    (offset_r),
    .cfg       (cfg_r),
    .res       (ofs)
  );

  // estimator state update
  always_comb begin
    fresh_nxt      = 1'b0;
    last_delay_nxt = delay;
    offset_nxt     = ofs.offset_nxt;
    prev_ts_nxt    = ofs.ts_advance ? s1_ts_r  : prev_ts_r;
    prev_seq_nxt   = ofs.ts_advance ? s1_seq_r : prev_seq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r      <= 1'b1;
      last_delay_r <= '0;
      jitter_r     <= '0;
      prev_ts_r    <= '0;
      prev_seq_r   <= '0;
      offset_r     <= '0;
    end else if (advance) begin
      fresh_r      <= fresh_nxt;
      last_delay_r <= last_delay_nxt;
      jitter_r     <= jitter_nxt;
      prev_ts_r    <= prev_ts_nxt;
      prev_seq_r   <= prev_seq_nxt;
      offset_r     <= offset_nxt;
    end
  end

  // result register
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_point_r <= s1_ts_r + offset_nxt;
      out_upd_r   <= ofs.updated;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_playout_point  = out_point_r;
  assign out_offset_updated = out_upd_r;

  // checks
  `PDA_ASSERT_IMP(a_stall_only_full, !s1_valid_r, !in_stall,
    "input stalled with empty input register")
  `PDA_ASSERT_NXT(a_advance_fills_out, advance, out_valid,
    "processed request left no result")
  `PDA_ASSERT_NXT(a_first_updates, advance && fresh_r, out_offset_updated,
    "first request after reset did not set the offset")
  `PDA_ASSERT_NXT(a_offset_hold, advance && !ofs.updated, $stable(offset_r),
    "playout offset changed without a recompute")

endmodule

// File: bench/pda_checker.sv
// playout delay adapter checker: watches the header, result and register channels
// predicts each playout point from its own copy of the estimator and compares in order
// depends on pda_pkg for widths, constants and register indexes
`timescale 1ns / 1ps

module pda_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pda_pkg::TS_W-1:0]      in_media_timestamp,
  input  logic [pda_pkg::SEQ_W-1:0]     in_sequence_number,
  input  logic                          in_marker_bit,
  input  logic [pda_pkg::TS_W-1:0]      in_arrival_time,
  input  logic [pda_pkg::CONC_W-1:0]    in_concealed_run,
  input  logic                          in_format_restart,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pda_pkg::TS_W-1:0]      out_playout_point,
  input  logic                          out_offset_updated,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pda_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            pending_count
);
  import pda_pkg::*;

  typedef struct packed {
    logic [TS_W-1:0] point;
    logic            updated;
  } playout_t;

  playout_t         playout_q[$];

  // register copies
  logic [CFG_W-1:0] unit_samples;
  logic [CFG_W-1:0] cushion;
  logic             clk_differs;

  // estimator copy
  logic             first_pending;
  logic [TS_W-1:0]  last_delay;
  logic [JIT_W-1:0] jitter;
  logic [TS_W-1:0]  prev_ts;
  logic [SEQ_W-1:0] prev_seq;
  logic [TS_W-1:0]  ofs;

  // wrapping timestamp order
  function automatic logic is_after(input logic [TS_W-1:0] a, input logic [TS_W-1:0] b);
    logic [TS_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TS_W-1];
  endfunction

  // advance the estimator by one header and return its playout point
  function automatic playout_t predict_playout(
    input logic [TS_W-1:0]   ts,
    input logic [SEQ_W-1:0]  seq,
    input logic              marker,
    input logic [TS_W-1:0]   arrival,
    input logic [CONC_W-1:0] conc,
    input logic              restart
  );
    logic [TS_W-1:0] delay;
    logic [TS_W-1:0] span;
    logic [TS_W-1:0] gap_edge;
    logic [TS_W-1:0] spread;
    longint          dd;
    longint          dev;
    longint          term;
    logic            talk_start;
    playout_t        res;
    delay = arrival - ts;
    talk_start = marker;
    res.updated = 1'b0;
    if (restart || first_pending) begin
      // first header of a stream seeds the estimator
      first_pending = 1'b0;
      last_delay = delay;
      jitter = JIT_INIT;
      prev_ts = ts - 1;
      talk_start = 1'b1;
    end else begin
      // 1/16 running average, step rounded toward minus infinity
      dd = longint'($signed(delay)) - longint'($signed(last_delay));
      if (dd < 0) dd = -dd;
      dev = (dd <<< JIT_FRAC_BITS) - longint'(jitter);
      jitter = JIT_W'(longint'(jitter) + (dev >>> JIT_AVG_SHIFT));
      last_delay = delay;
    end
    if (is_after(ts, prev_ts)) begin
      span = TS_W'((int'(seq) - int'(prev_seq)) * int'(unit_samples) * (1 << GAP_SHIFT));
      gap_edge = prev_ts + span + 1;
      if (talk_start || conc > CONCEAL_LIMIT || is_after(ts, gap_edge)) begin
        term = longint'(jitter >> JIT_FRAC_BITS) * JIT_MULT;
        if (term > JIT_CLAMP) term = JIT_CLAMP;
        spread = TS_W'(term) + cushion;
        if (clk_differs) spread = spread + unit_samples;
        ofs = last_delay + spread;
        res.updated = 1'b1;
      end
      prev_ts = ts;
      prev_seq = seq;
    end
    res.point = ts + ofs;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [TS_W-1:0] want,
                               input logic [TS_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want, got);
  endtask

  // channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    playout_t want;
    if (!rst_n) begin
      unit_samples = UNIT_LENGTH_RST;
      cushion = CUSHION_RST;
      clk_differs = 1'b0;
      first_pending = 1'b1;
      last_delay = '0;
      jitter = '0;
      prev_ts = '0;
      prev_seq = '0;
      ofs = '0;
      playout_q.delete();
    end else begin
      // register write request
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_UNIT_LENGTH:   unit_samples = cfg_data;
          CFG_CUSHION:       cushion = cfg_data;
          CFG_CLOCK_DIFFERS: clk_differs = cfg_data[0];
          default: ;
        endcase
      end
      // result request against the oldest expectation
      if (out_valid && !out_stall) begin
        if (playout_q.size() == 0) begin
          note_mismatch("unexpected result", '0, out_playout_point);
        end else begin
          want = playout_q.pop_front();
          if (out_playout_point !== want.point)
            note_mismatch("playout_point", want.point, out_playout_point);
          if (out_offset_updated !== want.updated)
            note_mismatch("offset_updated", TS_W'(want.updated), TS_W'(out_offset_updated));
        end
      end
      // header request
      if (in_valid && !in_stall)
        playout_q.push_back(predict_playout(in_media_timestamp, in_sequence_number,
                                            in_marker_bit, in_arrival_time,
                                            in_concealed_run, in_format_restart));
    end
    pending_count = playout_q.size();
  end

endmodule

// File: bench/tb.sv
// testbench top for the playout delay adapter: clock, reset, header and register stimulus
// directed headers first, then packet streams over several register settings
// depends on pda_pkg, pda_checker and playout_delay_adapter_top
`timescale 1ns / 1ps

module tb;
  import pda_pkg::*;

  localparam int RUN_LIMIT = 1000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TS_W-1:0]      in_media_timestamp = '0;
  logic [SEQ_W-1:0]     in_sequence_number = '0;
  logic                 in_marker_bit = 1'b0;
  logic [TS_W-1:0]      in_arrival_time = '0;
  logic [CONC_W-1:0]    in_concealed_run = '0;
  logic                 in_format_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TS_W-1:0]      out_playout_point;
  logic                 out_offset_updated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int               mismatch_total;
  int               pending_total;
  int               cycle_count = 0;
  logic [CFG_W-1:0] unit_now = UNIT_LENGTH_RST;
  bit               gaps_on = 1'b1;

  playout_delay_adapter_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_media_timestamp (in_media_timestamp),
    .in_sequence_number (in_sequence_number),
    .in_marker_bit      (in_marker_bit),
    .in_arrival_time    (in_arrival_time),
    .in_concealed_run   (in_concealed_run),
    .in_format_restart  (in_format_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_playout_point  (out_playout_point),
    .out_offset_updated (out_offset_updated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  pda_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_media_timestamp (in_media_timestamp),
    .in_sequence_number (in_sequence_number),
    .in_marker_bit      (in_marker_bit),
    .in_arrival_time    (in_arrival_time),
    .in_concealed_run   (in_concealed_run),
    .in_format_restart  (in_format_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_playout_point  (out_playout_point),
    .out_offset_updated (out_offset_updated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_total),
    .pending_count      (pending_total)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls: short bursts, a few long ones, and quiet stretches
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b0;
        hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      end
      repeat (hold) @(negedge clk);
    end
  end

  // hold the sender off by dropping in_valid
  task automatic idle_for(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // one header request, held until accepted, then an optional gap
  task automatic send_header(input logic [TS_W-1:0] ts, input logic [SEQ_W-1:0] seq,
                             input logic marker, input logic [TS_W-1:0] arrival,
                             input logic [CONC_W-1:0] conc, input logic restart);
    int r;
    @(negedge clk);
    in_valid <= 1'b1;
    in_media_timestamp <= ts;
    in_sequence_number <= seq;
    in_marker_bit <= marker;
    in_arrival_time <= arrival;
    in_concealed_run <= conc;
    in_format_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r < 25) idle_for($urandom_range(1, 3));
      else if (r < 27) idle_for($urandom_range(20, 80));
    end
  endtask

  // pause the sender until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_total != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_UNIT_LENGTH) unit_now = value;
  endtask

  // packet streams with random content, plus reordering, gaps and noise
  task automatic run_phase(input int count);
    int          left;
    int          burst_len;
    int          r;
    int          skip;
    int          jit_amp;
    logic [31:0] ts_now;
    logic [31:0] ts_send;
    logic [31:0] delay_base;
    logic [15:0] seq_now;
    logic [15:0] seq_send;
    logic [7:0]  conc;
    left = count;
    while (left > 0) begin
      // new stream
      burst_len = $urandom_range(10, 60);
      ts_now = $urandom;
      seq_now = 16'($urandom);
      delay_base = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20000);
      jit_amp = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 60);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < burst_len && left > 0; k++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) == 0) drain_results();
        if (r < 8) begin
          // noise
          send_header($urandom, 16'($urandom), 1'($urandom_range(0, 1)), $urandom,
                      8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end else begin
          if (r < 13) begin
            // late packet from earlier in the stream
            skip = $urandom_range(1, 4);
            ts_send = ts_now - unit_now * skip;
            seq_send = 16'(seq_now - skip);
          end else begin
            skip = (r < 18) ? $urandom_range(2, 30) : 1;
            seq_now = 16'(seq_now + skip);
            ts_now = ts_now + unit_now * skip;
            // timestamp jump with no sequence skip
            if (r >= 18 && r < 21) ts_now = ts_now + unit_now * $urandom_range(9, 40);
            ts_send = ts_now;
            seq_send = seq_now;
          end
          if ($urandom_range(0, 9) == 0) conc = 8'($urandom_range(0, 255));
          else if ($urandom_range(0, 5) == 0) conc = 8'($urandom_range(1, 4));
          else conc = '0;
          send_header(ts_send, seq_send, (k == 0) || ($urandom_range(0, 39) == 0),
                      ts_send + delay_base + $urandom_range(0, jit_amp), conc,
                      $urandom_range(0, 149) == 0);
        end
        left--;
      end
    end
  endtask

  // main sequence
  initial begin
    logic [CFG_W-1:0] u_val;
    logic [CFG_W-1:0] c_val;
    logic             d_val;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first header after reset, then a steady stream
    send_header(32'd0, 16'd0, 1'b0, 32'd0, 8'd0, 1'b0);
    send_header(32'd160, 16'd1, 1'b0, 32'd165, 8'd0, 1'b0);
    send_header(32'd320, 16'd2, 1'b0, 32'd330, 8'd0, 1'b0);
    // talkspurt start
    send_header(32'd480, 16'd3, 1'b1, 32'd485, 8'd0, 1'b0);
    // concealment run at and above the limit, then saturated
    send_header(32'd640, 16'd4, 1'b0, 32'd650, 8'd4, 1'b0);
    send_header(32'd800, 16'd5, 1'b0, 32'd805, 8'd5, 1'b0);
    send_header(32'd960, 16'd6, 1'b0, 32'd1000, 8'd255, 1'b0);
    // older and equal timestamps
    send_header(32'd800, 16'd5, 1'b0, 32'd900, 8'd0, 1'b0);
    send_header(32'd960, 16'd6, 1'b0, 32'd970, 8'd0, 1'b0);
    // timestamp gap without a sequence skip, then a matched skip
    send_header(32'd4160, 16'd7, 1'b0, 32'd4170, 8'd0, 1'b0);
    send_header(32'd7360, 16'd27, 1'b0, 32'd7370, 8'd0, 1'b0);
    // format restart, then sequence wrap
    send_header(32'h1234_5678, 16'hFFFF, 1'b0, 32'h1234_5700, 8'd0, 1'b1);
    send_header(32'h1234_5718, 16'h0000, 1'b0, 32'h1234_57A0, 8'd0, 1'b0);
    // delay swings across the signed range, jitter term clamps
    send_header(32'hFFFF_FFFF, 16'd1, 1'b0, 32'h7FFF_FFFE, 8'd0, 1'b0);
    send_header(32'h0000_009F, 16'd2, 1'b0, 32'h8000_009F, 8'd0, 1'b0);
    send_header(32'h0000_013F, 16'd3, 1'b1, 32'h0000_013F, 8'd0, 1'b0);
    // all ones, then a timestamp exactly half the range away
    send_header(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_header(32'h7FFF_FFFF, 16'h0000, 1'b0, 32'h0000_0000, 8'd0, 1'b0);
    // steady delay lets the jitter decay
    for (int k = 1; k <= 6; k++)
      send_header(32'hFFFF_FFFF + 32'(160 * k), 16'hFFFF + 16'(k), 1'b0,
                  32'hFFFF_FFFF + 32'(160 * k), 8'd0, 1'b0);

    // register settings: reset values, then extremes, then random ones
    for (int p = 0; p < 6; p++) begin
      drain_results();
      unique case (p)
        0: begin u_val = UNIT_LENGTH_RST; c_val = CUSHION_RST; d_val = 1'b0; end
        1: begin u_val = 16'd1; c_val = 16'hFFFF; d_val = 1'b1; end
        2: begin u_val = 16'hFFFF; c_val = '0; d_val = 1'b1; end
        3: begin u_val = 16'hFFFF; c_val = 16'hFFFF; d_val = 1'b0; end
        default: begin
          u_val = 16'($urandom_range(1, 2000));
          c_val = 16'($urandom_range(0, 65535));
          d_val = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(CFG_UNIT_LENGTH, u_val);
      write_reg(CFG_CUSHION, c_val);
      write_reg(CFG_CLOCK_DIFFERS, CFG_W'(d_val));
      run_phase(250);
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatch_total == 0 && pending_total == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/pda_pkg.sv
hdl/pda_jitter.sv
hdl/pda_offset.sv
hdl/playout_delay_adapter_top.sv
bench/pda_checker.sv
bench/tb.sv
